// ===== rtl/cmg_momentum_column_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the momentum column block
// Compiled away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CMG_MOMENTUM_COLUMN_MACROS_SVH
`define CMG_MOMENTUM_COLUMN_MACROS_SVH

`ifndef SYNTHESIS
`define CMG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CMG_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CMG_ASSERT(lbl, clk, rst_n, prop, msg)
`define CMG_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/cmg_pkg.sv =====
// ----------------------------------------------------------------------------
// cmg_pkg
// Widths, constants and types shared by the momentum column block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmg_pkg;

  localparam int IDX_W = 3;
  localparam int ANG_W = 16;
  localparam int D_W   = 16;
  localparam int HS_W  = 16;
  localparam int OW    = 19;

  // CORDIC datapath: x, y in Q.30, z in 2^32 counts per turn
  localparam int XYW = 33;
  localparam int ZW  = 33;

  // post-processing widths
  localparam int CSW = 18;              // rounded cos / sin, Q.14
  localparam int PW  = CSW + D_W;       // single product, Q.28
  localparam int SW  = PW + 1;          // sum of two products
  localparam int MW  = SW + HS_W + 1;   // times rotor momentum, Q.36
  localparam int RW  = MW - 28;         // after rounding to Q.8

  localparam int TAB_LEN = 24;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  localparam logic signed [XYW-1:0] CORDIC_X0 = XYW'(652032874);
  localparam logic signed [XYW-1:0] RND_CS    = XYW'(32768);
  localparam logic signed [MW-1:0]  RND_OUT   = MW'(134217728);

  localparam logic [HS_W-1:0]      HS_RESET = HS_W'(256);
  localparam logic signed [RW-1:0] SAT_MAX  = RW'(262143);
  localparam logic signed [RW-1:0] SAT_MIN  = RW'(-262144);
  localparam logic signed [OW-1:0] OUT_MAX  = OW'(262143);
  localparam logic signed [OW-1:0] OUT_MIN  = OW'(-262144);

  typedef logic [2:0][D_W-1:0] cmg_dvec_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic             flip;
    cmg_dvec_t        d1;
    cmg_dvec_t        d2;
  } cmg_tag_t;

  typedef struct packed {
    cmg_tag_t               tag;
    logic signed [XYW-1:0]  x;
    logic signed [XYW-1:0]  y;
    logic signed [ZW-1:0]   z;
  } cmg_cell_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
  } cmg_meta_t;

endpackage

// ===== rtl/cmg_in_if.sv =====
// ----------------------------------------------------------------------------
// cmg_in_if
// Input channel: one gyro description per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cmg_in_if import cmg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        gimbal_index;
  logic signed [ANG_W-1:0] gimbal_angle;
  logic signed [D_W-1:0]   dcm_col1_x;
  logic signed [D_W-1:0]   dcm_col1_y;
  logic signed [D_W-1:0]   dcm_col1_z;
  logic signed [D_W-1:0]   dcm_col2_x;
  logic signed [D_W-1:0]   dcm_col2_y;
  logic signed [D_W-1:0]   dcm_col2_z;
  logic                    last_gimbal;

  modport source (
    output valid, gimbal_index, gimbal_angle, dcm_col1_x, dcm_col1_y, dcm_col1_z,
           dcm_col2_x, dcm_col2_y, dcm_col2_z, last_gimbal,
    input  ready
  );

  modport sink (
    input  valid, gimbal_index, gimbal_angle, dcm_col1_x, dcm_col1_y, dcm_col1_z,
           dcm_col2_x, dcm_col2_y, dcm_col2_z, last_gimbal,
    output ready
  );
endinterface

// ===== rtl/cmg_out_if.sv =====
// ----------------------------------------------------------------------------
// cmg_out_if
// Output channel: one Jacobian column per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cmg_out_if import cmg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     column_index;
  logic signed [OW-1:0] momentum_x;
  logic signed [OW-1:0] momentum_y;
  logic signed [OW-1:0] momentum_z;
  logic                 last_column;
  logic                 clipped;

  modport source (
    output valid, column_index, momentum_x, momentum_y, momentum_z, last_column,
           clipped,
    input  ready
  );

  modport sink (
    input  valid, column_index, momentum_x, momentum_y, momentum_z, last_column,
           clipped,
    output ready
  );
endinterface

// ===== rtl/cmg_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// cmg_cordic_cell
// One rotation-mode CORDIC micro-rotation with its own valid and hold logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cmg_momentum_column_macros.svh"

module cmg_cordic_cell import cmg_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      up_valid_i,
  input  cmg_cell_t up_data_i,
  output logic      up_ready_o,
  output logic      dn_valid_o,
  output cmg_cell_t dn_data_o,
  input  logic      dn_ready_i
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[STAGE]);

  logic      load;
  logic      valid_q;
  cmg_cell_t data_q, data_d;

  assign load       = !valid_q || dn_ready_i;
  assign up_ready_o = load;
  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

  always_comb begin
    data_d.tag = up_data_i.tag;
    // rotate toward zero residual angle
    if (!up_data_i.z[ZW-1]) begin
      data_d.x = up_data_i.x - (up_data_i.y >>> STAGE);
      data_d.y = up_data_i.y + (up_data_i.x >>> STAGE);
      data_d.z = up_data_i.z - ATAN;
    end else begin
      data_d.x = up_data_i.x + (up_data_i.y >>> STAGE);
      data_d.y = up_data_i.y - (up_data_i.x >>> STAGE);
      data_d.z = up_data_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && up_valid_i) begin
      data_q <= data_d;
    end
  end

  `CMG_ASSERT(a_cell_hold, clk_i, rst_ni, (valid_q && !dn_ready_i) |=> (valid_q && $stable(data_q)), "cordic cell lost a stalled transaction")

endmodule

// ===== rtl/cmg_scale_pipe.sv =====
// ----------------------------------------------------------------------------
// cmg_scale_pipe
// Rounds sin/cos, forms hs*(cos*d1 + sin*d2) per axis, rounds and saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cmg_momentum_column_macros.svh"

module cmg_scale_pipe import cmg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            up_valid_i,
  input  cmg_cell_t       up_data_i,
  output logic            up_ready_o,
  input  logic [HS_W-1:0] rotor_momentum_i,
  cmg_out_if.source       out_o
);

  logic en0, en1, en2, en3;
  logic v0_q, v1_q, v2_q, v3_q;

  // stage 0: rounded cos and sin
  cmg_tag_t              tag0_q;
  logic signed [CSW-1:0] cos0_q, sin0_q, cos0_d, sin0_d;
  logic signed [XYW-1:0] xs, ys;

  // stage 1: products
  cmg_meta_t            meta1_q;
  logic signed [PW-1:0] p1_q [3];
  logic signed [PW-1:0] p2_q [3];
  logic signed [PW-1:0] p1_d [3];
  logic signed [PW-1:0] p2_d [3];

  // stage 2: scaled by rotor momentum
  cmg_meta_t            meta2_q;
  logic signed [MW-1:0] m2_q [3];
  logic signed [MW-1:0] m2_d [3];
  logic signed [SW-1:0] sum2;
  logic signed [HS_W:0] hs_s;

  // stage 3: output register
  cmg_meta_t            meta3_q;
  logic signed [OW-1:0] mom_q [3];
  logic signed [OW-1:0] mom_d [3];
  logic                 clip_q, clip_d;
  logic signed [RW-1:0] r3;

  assign en3        = !v3_q || out_o.ready;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign en0        = !v0_q || en1;
  assign up_ready_o = en0;

  always_comb begin
    xs     = (up_data_i.x + RND_CS) >>> 16;
    ys     = (up_data_i.y + RND_CS) >>> 16;
    cos0_d = up_data_i.tag.flip ? -CSW'(xs) : CSW'(xs);
    sin0_d = up_data_i.tag.flip ? -CSW'(ys) : CSW'(ys);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p1_d[k] = PW'(cos0_q) * PW'($signed(tag0_q.d1[k]));
      p2_d[k] = PW'(sin0_q) * PW'($signed(tag0_q.d2[k]));
    end
  end

  assign hs_s = $signed({1'b0, rotor_momentum_i});

  always_comb begin
    sum2 = '0;
    for (int k = 0; k < 3; k++) begin
      sum2    = SW'(p1_q[k]) + SW'(p2_q[k]);
      m2_d[k] = MW'(sum2) * MW'(hs_s);
    end
  end

  always_comb begin
    r3     = '0;
    clip_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      r3 = RW'((m2_q[k] + RND_OUT) >>> 28);
      if (r3 > SAT_MAX) begin
        mom_d[k] = OUT_MAX;
        clip_d   = 1'b1;
      end else if (r3 < SAT_MIN) begin
        mom_d[k] = OUT_MIN;
        clip_d   = 1'b1;
      end else begin
        mom_d[k] = OW'(r3);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= up_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && up_valid_i) begin
      tag0_q <= up_data_i.tag;
      cos0_q <= cos0_d;
      sin0_q <= sin0_d;
    end
    if (en1 && v0_q) begin
      meta1_q <= '{index: tag0_q.index, last: tag0_q.last};
      p1_q    <= p1_d;
      p2_q    <= p2_d;
    end
    if (en2 && v1_q) begin
      meta2_q <= meta1_q;
      m2_q    <= m2_d;
    end
    if (en3 && v2_q) begin
      meta3_q <= meta2_q;
      mom_q   <= mom_d;
      clip_q  <= clip_d;
    end
  end

  assign out_o.valid        = v3_q;
  assign out_o.column_index = meta3_q.index;
  assign out_o.last_column  = meta3_q.last;
  assign out_o.momentum_x   = mom_q[0];
  assign out_o.momentum_y   = mom_q[1];
  assign out_o.momentum_z   = mom_q[2];
  assign out_o.clipped      = clip_q;

  `CMG_ASSERT(a_clip_at_rail, clk_i, rst_ni, (v3_q && clip_q) |-> (mom_q[0] == OUT_MAX || mom_q[0] == OUT_MIN || mom_q[1] == OUT_MAX || mom_q[1] == OUT_MIN || mom_q[2] == OUT_MAX || mom_q[2] == OUT_MIN), "clipped set with no component at a rail")

endmodule

// ===== rtl/cmg_momentum_column.sv =====
// Path to output valid: one register per CORDIC cell, then the scale pipe stages.
// One gyro per cycle if unstalled; each CORDIC cell and scale stage holds one item.
// Stalls propagate per stage, so bubbles collapse and input keeps flowing
// while a finished column waits in the output register.
// Reset clears all valid bits and sets rotor_momentum to 256 (1.0 in Q8.8).
// ----------------------------------------------------------------------------
// cmg_momentum_column
// One column of the CMG angular momentum Jacobian per gyro: a chain of CORDIC
// cells produces sin/cos, a short pipeline scales and saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cmg_momentum_column_macros.svh"

module cmg_momentum_column import cmg_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [HS_W-1:0] cfg_wdata_i,
  cmg_in_if.sink          in_i,
  cmg_out_if.source       out_o
);

  logic [HS_W-1:0]  rotor_momentum_q;
  logic             cell_valid [CORDIC_STAGES+1];
  logic             cell_ready [CORDIC_STAGES+1];
  cmg_cell_t        cell_data  [CORDIC_STAGES+1];
  logic             flip;
  logic [ANG_W-1:0] resid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotor_momentum_q <= HS_RESET;
    end else if (cfg_we_i) begin
      rotor_momentum_q <= cfg_wdata_i;
    end
  end

  // fold second and third quadrant by half a turn, negate sin/cos afterwards
  assign flip  = in_i.gimbal_angle[ANG_W-1] ^ in_i.gimbal_angle[ANG_W-2];
  assign resid = {in_i.gimbal_angle[ANG_W-1] ^ flip, in_i.gimbal_angle[ANG_W-2:0]};

  always_comb begin
    cell_data[0].tag.index = in_i.gimbal_index;
    cell_data[0].tag.last  = in_i.last_gimbal;
    cell_data[0].tag.flip  = flip;
    cell_data[0].tag.d1    = {in_i.dcm_col1_z, in_i.dcm_col1_y, in_i.dcm_col1_x};
    cell_data[0].tag.d2    = {in_i.dcm_col2_z, in_i.dcm_col2_y, in_i.dcm_col2_x};
    cell_data[0].x         = CORDIC_X0;
    cell_data[0].y         = '0;
    cell_data[0].z         = $signed({resid[ANG_W-1], resid, 16'h0000});
  end

  assign cell_valid[0] = in_i.valid;
  assign in_i.ready    = cell_ready[0];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    cmg_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (cell_valid[g]),
      .up_data_i  (cell_data[g]),
      .up_ready_o (cell_ready[g]),
      .dn_valid_o (cell_valid[g+1]),
      .dn_data_o  (cell_data[g+1]),
      .dn_ready_i (cell_ready[g+1])
    );
  end

  cmg_scale_pipe u_scale (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .up_valid_i       (cell_valid[CORDIC_STAGES]),
    .up_data_i        (cell_data[CORDIC_STAGES]),
    .up_ready_o       (cell_ready[CORDIC_STAGES]),
    .rotor_momentum_i (rotor_momentum_q),
    .out_o            (out_o)
  );

  `CMG_ASSERT(a_accept_enters, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> cell_valid[1], "accepted transaction did not enter the first cell")

endmodule
